// ----- hdl/npsd_pkg.sv -----
// Shared types and constants for the 3D nearest point search block.
// Holds the transaction payload structs, command and register codes, and the sequencer states.
// No dependencies.
package npsd_pkg;

  localparam int SLOT_W     = 10;
  localparam int COORD_IN_W = 24;
  localparam int DIST_W     = 50;
  localparam int COUNT_W    = 11;
  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 50;
  localparam int AXES       = 3;
  localparam int MAG_W      = 26;
  localparam int MAG_EXT_W  = 34;
  localparam int SQ_W       = 2 * MAG_W;

  localparam logic [DIST_W-1:0]    DIST_MAX  = {DIST_W{1'b1}};
  localparam logic [MAG_EXT_W-1:0] MAG_LIMIT = MAG_EXT_W'(1) << (MAG_W - 1);

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  localparam logic [CFG_ADDR_W-1:0] REG_MAX_DIST_SQ  = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] REG_TARGET_COUNT = 1'b1;

  typedef struct packed {
    logic                         cmd;
    logic [SLOT_W-1:0]            slot;
    logic signed [COORD_IN_W-1:0] coord_x;
    logic signed [COORD_IN_W-1:0] coord_y;
    logic signed [COORD_IN_W-1:0] coord_z;
  } npsd_in_t;

  typedef struct packed {
    logic              found;
    logic [SLOT_W-1:0] nearest_slot;
    logic [DIST_W-1:0] nearest_dist_sq;
  } npsd_out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } npsd_state_e;

endpackage

// ----- hdl/nearest_point_search_3d.sv -----
// A query reads n = min(target_count, MAX_POINTS) stored points through the distance unit
// and then gives its result strobe; with n of zero it goes straight to the result. No new
// command is accepted while a query is in flight. The single read port of the point store
// feeds one shared distance unit one point per cycle; a load is written in the cycle it is
// accepted and leaves the block idle. Reset clears the sequencer and the registers (max_dist_sq 0,
// target_count 1); the point store is not cleared. The receiver cannot stall a result.
module nearest_point_search_3d
  import npsd_pkg::*;
#(
  parameter int MAX_POINTS  = 1024,
  parameter int COORD_WIDTH = 24
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  npsd_in_t              cmd_i,
  output logic                  done_o,
  output npsd_out_t             result_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  localparam int AW  = $clog2(MAX_POINTS);
  localparam int CNW = $clog2(MAX_POINTS + 1);
  localparam int DW  = COORD_WIDTH + 1;
  localparam int PW  = AXES * COORD_WIDTH;

  npsd_state_e state_q, state_d;

  logic [DIST_W-1:0]  max_dist_q;
  logic [COUNT_W-1:0] count_q;

  logic [CNW-1:0] cnt_q, cnt_d;
  logic [CNW-1:0] n_q;
  logic [CNW-1:0] n_start;
  logic           last_issue;
  logic           issue;
  logic           accept;

  logic signed [COORD_WIDTH-1:0] in_coord [AXES];
  logic signed [COORD_WIDTH-1:0] q_q      [AXES];

  logic [PW-1:0] mem [MAX_POINTS];
  logic [PW-1:0] rd_q;
  logic          slot_ok;

  logic          v1_q, v2_q, v3_q, v4_q;
  logic          last1_q, last2_q, last3_q, last4_q;
  logic [AW-1:0] idx1_q, idx2_q, idx3_q, idx4_q;

  logic [AXES-1:0][MAG_W-1:0] mag_d, mag_q;
  logic                       ovf_d, ovf2_q, ovf3_q;
  logic [AXES-1:0][SQ_W-1:0]  sq_q;
  logic [SQ_W-1:0]            sum;
  logic [DIST_W-1:0]          dist_d, dist_q;

  logic              any_q;
  logic [DIST_W-1:0] best_q;
  logic [AW-1:0]     best_idx_q;
  logic              found;

  logic      done_q;
  npsd_out_t res_q;

  assign accept = start && !busy;
  assign busy   = (state_q != ST_IDLE);

  assign in_coord[0] = COORD_WIDTH'(cmd_i.coord_x);
  assign in_coord[1] = COORD_WIDTH'(cmd_i.coord_y);
  assign in_coord[2] = COORD_WIDTH'(cmd_i.coord_z);

  assign n_start = (32'(count_q) > 32'(MAX_POINTS)) ? CNW'(MAX_POINTS) : CNW'(count_q);
  assign last_issue = (CNW'(cnt_q + 1'b1) == n_q);
  assign slot_ok = (32'(cmd_i.slot) < 32'(MAX_POINTS));

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_dist_q <= '0;
      count_q    <= COUNT_W'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        REG_MAX_DIST_SQ:  max_dist_q <= DIST_W'(cfg_wdata_i);
        REG_TARGET_COUNT: count_q    <= COUNT_W'(cfg_wdata_i);
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    issue   = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && cmd_i.cmd == CMD_QUERY) begin
          cnt_d   = '0;
          state_d = (n_start == '0) ? ST_FINISH : ST_SCAN;
        end
      end
      ST_SCAN: begin
        issue = 1'b1;
        cnt_d = CNW'(cnt_q + 1'b1);
        if (last_issue) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (v4_q && last4_q) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      n_q     <= '0;
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
      v4_q    <= 1'b0;
      any_q   <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      v1_q    <= issue;
      v2_q    <= v1_q;
      v3_q    <= v2_q;
      v4_q    <= v3_q;
      done_q  <= (state_q == ST_FINISH);
      if (state_q == ST_IDLE && accept && cmd_i.cmd == CMD_QUERY) begin
        n_q   <= n_start;
        any_q <= 1'b0;
      end else if (v4_q) begin
        any_q <= 1'b1;
      end
    end
  end

  // Point store: one write port for loads, one registered read port for the scan.
  always_ff @(posedge clk_i) begin
    if (accept && cmd_i.cmd == CMD_LOAD && slot_ok) begin
      mem[AW'(cmd_i.slot)] <= {in_coord[2], in_coord[1], in_coord[0]};
    end
    rd_q <= mem[cnt_q[AW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && accept) begin
      for (int a = 0; a < AXES; a++) begin
        q_q[a] <= in_coord[a];
      end
    end
  end

  // Absolute differences, with a flag for any axis too far apart to square.
  always_comb begin
    logic signed [DW-1:0]    diff;
    logic [DW-1:0]           mag;
    logic [MAG_EXT_W-1:0]    mag_ext;
    ovf_d = 1'b0;
    for (int a = 0; a < AXES; a++) begin
      diff    = DW'(q_q[a]) - DW'($signed(rd_q[a*COORD_WIDTH +: COORD_WIDTH]));
      mag     = diff[DW-1] ? DW'(-diff) : DW'(diff);
      mag_ext = MAG_EXT_W'(mag);
      if (mag_ext > MAG_LIMIT) begin
        ovf_d = 1'b1;
      end
      mag_d[a] = mag_ext[MAG_W-1:0];
    end
  end

  always_comb begin
    sum = sq_q[0] + sq_q[1] + sq_q[2];
    if (ovf3_q || sum > SQ_W'(DIST_MAX)) begin
      dist_d = DIST_MAX;
    end else begin
      dist_d = sum[DIST_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    last1_q <= issue && last_issue;
    idx1_q  <= cnt_q[AW-1:0];
    mag_q   <= mag_d;
    ovf2_q  <= ovf_d;
    last2_q <= last1_q;
    idx2_q  <= idx1_q;
    for (int a = 0; a < AXES; a++) begin
      sq_q[a] <= mag_q[a] * mag_q[a];
    end
    ovf3_q  <= ovf2_q;
    last3_q <= last2_q;
    idx3_q  <= idx2_q;
    dist_q  <= dist_d;
    last4_q <= last3_q;
    idx4_q  <= idx3_q;
    if (v4_q && (!any_q || dist_q < best_q)) begin
      best_q     <= dist_q;
      best_idx_q <= idx4_q;
    end
  end

  assign found = any_q && (best_q <= max_dist_q);

  always_ff @(posedge clk_i) begin
    if (state_q == ST_FINISH) begin
      res_q.found           <= found;
      res_q.nearest_slot    <= found ? SLOT_W'(best_idx_q) : '0;
      res_q.nearest_dist_sq <= found ? best_q : '0;
    end
  end

  assign done_o   = done_q;
  assign result_o = res_q;

endmodule

// ----- hdl/npsd_checker.sv -----
// Port-level checks for the 3D nearest point search block.
// Depends on npsd_pkg; bound to nearest_point_search_3d at the end of this file.
module npsd_checker
  import npsd_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      start,
  input logic      busy,
  input npsd_in_t  cmd_i,
  input logic      done_o,
  input npsd_out_t result_o
);

  // A result is shown only once the block has returned to idle.
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while busy");

  // Each query transaction gives one single-cycle result.
  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe repeated");

  // A not-found result carries zero slot and distance.
  a_not_found_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !result_o.found) |->
      (result_o.nearest_slot == '0 && result_o.nearest_dist_sq == '0))
    else $error("not-found result with nonzero fields");

  // The block becomes busy only after accepting a query.
  a_busy_from_query: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy) |-> ($past(start) && $past(cmd_i.cmd) == CMD_QUERY))
    else $error("busy without a query");

  // A load completes in the cycle it is accepted.
  a_load_no_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && cmd_i.cmd == CMD_LOAD) |=> !busy)
    else $error("load made the block busy");

endmodule

bind nearest_point_search_3d npsd_checker u_npsd_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .start    (start),
  .busy     (busy),
  .cmd_i    (cmd_i),
  .done_o   (done_o),
  .result_o (result_o)
);

// ----- sim/tb_nearest_point_search_3d.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for nearest_point_search_3d: loads target points, runs queries
// and compares every result with an in-bench brute force search over its own point copy.
// Depends on npsd_pkg and the nearest_point_search_3d RTL.
module tb_nearest_point_search_3d
  import npsd_pkg::*;
();

  localparam int MAX_POINTS = 1024;
  localparam int PRELOAD    = 256;
  localparam logic signed [COORD_IN_W-1:0] COORD_MIN = {1'b1, {(COORD_IN_W-1){1'b0}}};
  localparam logic signed [COORD_IN_W-1:0] COORD_MAX = {1'b0, {(COORD_IN_W-1){1'b1}}};

  class nearest_scoreboard;
    logic signed [COORD_IN_W-1:0] pts [MAX_POINTS][AXES];
    logic [DIST_W-1:0] max_dist_sq;
    logic [COUNT_W-1:0] target_count;
    npsd_out_t pending_results [$];
    int errors;

    function new();
      max_dist_sq = '0;
      target_count = 1;
      errors = 0;
    endfunction

    function void set_regs(logic [DIST_W-1:0] thr, logic [COUNT_W-1:0] cnt);
      max_dist_sq = thr;
      target_count = cnt;
    endfunction

    function logic [DIST_W-1:0] dist_to(npsd_in_t q, int s);
      logic signed [COORD_IN_W-1:0] qc [AXES];
      longint unsigned sum;
      longint unsigned m;
      longint d;
      qc = '{q.coord_x, q.coord_y, q.coord_z};
      sum = 0;
      for (int a = 0; a < AXES; a++) begin
        d = longint'(qc[a]) - longint'(pts[s][a]);
        m = (d < 0) ? -d : d;
        if (m > (64'd1 << 25)) return DIST_MAX;
        sum += m * m;
      end
      if (sum > DIST_MAX) return DIST_MAX;
      return sum[DIST_W-1:0];
    endfunction

    function npsd_out_t find_nearest(npsd_in_t q);
      npsd_out_t r;
      logic [DIST_W-1:0] best;
      logic [DIST_W-1:0] d;
      int best_slot;
      int n;
      r = '0;
      best = '0;
      best_slot = 0;
      n = (target_count > MAX_POINTS) ? MAX_POINTS : target_count;
      for (int i = 0; i < n; i++) begin
        d = dist_to(q, i);
        if (i == 0 || d < best) begin
          best = d;
          best_slot = i;
        end
      end
      if (n > 0 && best <= max_dist_sq) begin
        r.found = 1'b1;
        r.nearest_slot = SLOT_W'(best_slot);
        r.nearest_dist_sq = best;
      end
      return r;
    endfunction

    function void note_item(npsd_in_t it);
      if (it.cmd == CMD_LOAD) begin
        pts[it.slot] = '{it.coord_x, it.coord_y, it.coord_z};
      end else begin
        pending_results.insert(pending_results.size(), find_nearest(it));
      end
    endfunction

    function void check_result(npsd_out_t act);
      npsd_out_t want;
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result: found %0b slot %0d dist %0d",
                   act.found, act.nearest_slot, act.nearest_dist_sq);
        return;
      end
      want = pending_results.pop_front();
      if (act.found !== want.found || act.nearest_slot !== want.nearest_slot ||
          act.nearest_dist_sq !== want.nearest_dist_sq) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: found %0b/%0b slot %0d/%0d dist %0d/%0d (expected/actual)",
                   want.found, act.found, want.nearest_slot, act.nearest_slot,
                   want.nearest_dist_sq, act.nearest_dist_sq);
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  logic start;
  logic busy;
  npsd_in_t cmd_i;
  logic done_o;
  npsd_out_t result_o;
  logic cfg_we_i;
  logic [CFG_ADDR_W-1:0] cfg_addr_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  nearest_scoreboard sb = new();
  int idle_pct;

  nearest_point_search_3d dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .cmd_i      (cmd_i),
    .done_o     (done_o),
    .result_o   (result_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_addr_i (cfg_addr_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && done_o) sb.check_result(result_o);
  end

  function automatic logic signed [COORD_IN_W-1:0] clamp_coord(longint v);
    if (v > longint'(COORD_MAX)) v = longint'(COORD_MAX);
    if (v < longint'(COORD_MIN)) v = longint'(COORD_MIN);
    return COORD_IN_W'(v);
  endfunction

  function automatic logic signed [COORD_IN_W-1:0] rand_coord();
    case ($urandom_range(0, 9))
      0: return COORD_MIN;
      1: return COORD_MAX;
      2, 3, 4: return clamp_coord(longint'($urandom_range(0, 2047)) - 1024);
      default: return COORD_IN_W'($urandom);
    endcase
  endfunction

  function automatic npsd_in_t make_item(logic cmd, int slot, logic signed [COORD_IN_W-1:0] x,
                                         logic signed [COORD_IN_W-1:0] y,
                                         logic signed [COORD_IN_W-1:0] z);
    npsd_in_t it;
    it.cmd = cmd;
    it.slot = SLOT_W'(slot);
    it.coord_x = x;
    it.coord_y = y;
    it.coord_z = z;
    return it;
  endfunction

  function automatic npsd_in_t random_load(int n);
    int slot;
    int src;
    slot = (n > 0 && $urandom_range(99) < 70) ? $urandom_range(0, n - 1) :
                                                 $urandom_range(0, MAX_POINTS - 1);
    if ($urandom_range(99) < 20) begin
      src = $urandom_range(0, PRELOAD - 1);
      return make_item(CMD_LOAD, slot, sb.pts[src][0], sb.pts[src][1], sb.pts[src][2]);
    end
    return make_item(CMD_LOAD, slot, rand_coord(), rand_coord(), rand_coord());
  endfunction

  function automatic npsd_in_t random_query(int n);
    logic signed [COORD_IN_W-1:0] c [AXES];
    int s;
    int span;
    if (n > 0 && $urandom_range(99) < 60) begin
      s = $urandom_range(0, n - 1);
      span = ($urandom_range(0, 3) == 0) ? 0 : (1 << $urandom_range(0, 12));
      for (int a = 0; a < AXES; a++)
        c[a] = clamp_coord(longint'(sb.pts[s][a]) + $urandom_range(0, 2 * span) - span);
    end else begin
      for (int a = 0; a < AXES; a++) c[a] = rand_coord();
    end
    return make_item(CMD_QUERY, $urandom_range(0, MAX_POINTS - 1), c[0], c[1], c[2]);
  endfunction

  function automatic logic [DIST_W-1:0] pick_threshold();
    case ($urandom_range(0, 4))
      0: return '0;
      1: return DIST_MAX;
      2: return DIST_W'({$urandom, $urandom});
      3: return DIST_W'($urandom);
      default: return DIST_W'($urandom_range(0, 4096));
    endcase
  endfunction

  task automatic send_item(npsd_in_t it);
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < idle_pct);
    end
    start <= 1'b1;
    cmd_i <= it;
    do @(posedge clk_i); while (busy);
    sb.note_item(it);
  endtask

  task automatic load_point(int slot, logic signed [COORD_IN_W-1:0] x,
                            logic signed [COORD_IN_W-1:0] y, logic signed [COORD_IN_W-1:0] z);
    send_item(make_item(CMD_LOAD, slot, x, y, z));
  endtask

  task automatic query_point(logic signed [COORD_IN_W-1:0] x, logic signed [COORD_IN_W-1:0] y,
                             logic signed [COORD_IN_W-1:0] z);
    send_item(make_item(CMD_QUERY, $urandom_range(0, MAX_POINTS - 1), x, y, z));
  endtask

  task automatic settle();
    start <= 1'b0;
    while (sb.pending_results.size() != 0 || busy) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_regs(logic [DIST_W-1:0] thr, logic [COUNT_W-1:0] cnt);
    cfg_we_i <= 1'b1;
    cfg_addr_i <= REG_MAX_DIST_SQ;
    cfg_wdata_i <= CFG_DATA_W'(thr);
    @(posedge clk_i);
    cfg_addr_i <= REG_TARGET_COUNT;
    cfg_wdata_i <= CFG_DATA_W'(cnt);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_regs(thr, cnt);
  endtask

  initial begin
    #8ms;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    int cnt;
    int items;
    int n;
    logic [DIST_W-1:0] thr;
    rst_ni = 1'b0;
    start = 1'b0;
    cmd_i = '0;
    cfg_we_i = 1'b0;
    cfg_addr_i = '0;
    cfg_wdata_i = '0;
    idle_pct = 34;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // The low slots are written once up front so that every count used later scans
    // only loaded slots.
    for (int s = 0; s < PRELOAD; s++) load_point(s, rand_coord(), rand_coord(), rand_coord());

    settle();
    write_regs(DIST_MAX, 4);
    load_point(0, COORD_MAX, COORD_MAX, COORD_MAX);
    load_point(1, COORD_MIN, COORD_MIN, COORD_MIN);
    load_point(2, 0, 0, 0);
    load_point(3, 0, 0, 0);
    query_point(COORD_MIN, COORD_MIN, COORD_MIN);
    query_point(COORD_MAX, COORD_MAX, COORD_MAX);
    query_point(1, -1, 0);
    query_point(COORD_MAX, COORD_MIN, 0);
    settle();
    write_regs('0, 4);
    query_point(0, 0, 0);
    query_point(1, 0, 0);
    settle();
    write_regs(2, 4);
    query_point(1, -1, 0);
    query_point(1, -1, 1);
    settle();
    write_regs(DIST_MAX, 0);
    query_point(5, 5, 5);
    settle();
    write_regs(DIST_MAX, 1);
    query_point(COORD_MIN, COORD_MIN, COORD_MIN);
    settle();
    write_regs(DIST_MAX, COUNT_W'(PRELOAD));
    query_point(rand_coord(), rand_coord(), rand_coord());

    for (int ph = 0; ph < 14; ph++) begin
      idle_pct = (ph == 7) ? 0 : 34;
      case (ph)
        3: begin
          cnt = 0;
          items = 10;
        end
        5: begin
          cnt = PRELOAD;
          items = 6;
        end
        7: begin
          cnt = $urandom_range(1, 24);
          items = 60;
        end
        10: begin
          cnt = $urandom_range(1, PRELOAD);
          items = 6;
        end
        default: begin
          cnt = $urandom_range(1, (ph % 4 == 0) ? 200 : 24);
          items = 22;
        end
      endcase
      thr = pick_threshold();
      settle();
      write_regs(thr, COUNT_W'(cnt));
      n = (cnt > MAX_POINTS) ? MAX_POINTS : cnt;
      repeat (items) begin
        if ($urandom_range(99) < 40) send_item(random_load(n));
        else send_item(random_query(n));
      end
    end

    start <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
